>>> hw/rtl/ppmd_pkg.sv
package ppmd_pkg;

    // Item kinds carried in the opcode field.
    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_EDGE = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } opcode_t;

    // Configuration register indexes.
    localparam logic [1:0] REG_PAUSE_LIMIT     = 2'd0;
    localparam logic [1:0] REG_TIMEOUT_RELOAD  = 2'd1;
    localparam logic [1:0] REG_ACTIVE_CHANNELS = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [7:0] PAUSE_LIMIT_RST     = 8'd3;
    localparam logic [7:0] TIMEOUT_RELOAD_RST  = 8'd7;
    localparam logic [3:0] ACTIVE_CHANNELS_RST = 4'd9;

    // Saturation points of the position and pause counters.
    localparam logic [6:0] POS_MAX   = 7'd127;
    localparam logic [7:0] PAUSE_MAX = 8'd255;

    // Widest channel and history slot index the design supports.
    localparam int CH_IDX_W   = 4;
    localparam int SLOT_IDX_W = 6;

    // Input word.
    typedef struct packed {
        logic [1:0]  opcode;
        logic        pin_high;
        logic [15:0] timestamp;
        logic [3:0]  read_channel;
        logic [3:0]  read_slot;
        logic        read_latest;
    } in_word_t;

    // Output word.
    typedef struct packed {
        logic        stored;
        logic [3:0]  channel;
        logic [15:0] width;
        logic [3:0]  slot;
        logic [15:0] read_data;
        logic        signal_present;
        logic        synced;
    } out_word_t;

    // Classified word passed from the front end to the store side.
    typedef struct packed {
        logic                  stored;
        logic [CH_IDX_W-1:0]   channel;
        logic [15:0]           width;
        logic [SLOT_IDX_W-1:0] slot;
        logic                  rd_use;
        logic                  rd_latest;
        logic [CH_IDX_W-1:0]   rd_channel;
        logic [SLOT_IDX_W-1:0] rd_slot;
        logic                  signal_present;
        logic                  synced;
    } cmd_t;

endpackage

>>> hw/rtl/ppmd_front.sv
module ppmd_front
    import ppmd_pkg::*;
#(
    parameter int MAX_CHANNELS  = 10,
    parameter int HISTORY_DEPTH = 16,
    parameter int TIME_WIDTH    = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_word_t   in_data,
    input  logic       q_full,
    input  logic       clearing,
    output logic       push,
    output cmd_t       push_cmd
);

    localparam int CAP_W  = (TIME_WIDTH < 16) ? TIME_WIDTH : 16;
    localparam int SLOT_W = $clog2(HISTORY_DEPTH);

    // Configuration registers.
    logic [7:0] pause_limit_reg;
    logic [7:0] timeout_reload_reg;
    logic [3:0] active_channels_reg;

    // Decoder state.
    logic              synced_reg, synced_next;
    logic [6:0]        pos_reg, pos_next;
    logic [CAP_W-1:0]  last_reg, last_next;
    logic [7:0]        pause_reg, pause_next;
    logic [7:0]        timeout_reg, timeout_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    logic [4:0]        eff_limit;
    logic [CAP_W-1:0]  diff;
    logic [7:0]        pause_inc;
    logic              accept;
    cmd_t              cmd;

    assign in_ready = !q_full && !clearing;
    assign accept   = in_valid && in_ready;
    assign push     = accept;
    assign push_cmd = cmd;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pause_limit_reg     <= PAUSE_LIMIT_RST;
            timeout_reload_reg  <= TIMEOUT_RELOAD_RST;
            active_channels_reg <= ACTIVE_CHANNELS_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_PAUSE_LIMIT:     pause_limit_reg     <= cfg_data;
                REG_TIMEOUT_RELOAD:  timeout_reload_reg  <= cfg_data;
                REG_ACTIVE_CHANNELS: active_channels_reg <= cfg_data[3:0];
                default:             ;
            endcase
        end
    end

    // Channel count in effect, clamped to the channels the store holds.
    always_comb
    begin
        if ({1'b0, active_channels_reg} > 5'(MAX_CHANNELS))
            eff_limit = 5'(MAX_CHANNELS);
        else
            eff_limit = {1'b0, active_channels_reg};
    end

    assign diff      = in_data.timestamp[CAP_W-1:0] - last_reg;
    assign pause_inc = (pause_reg == PAUSE_MAX) ? PAUSE_MAX : pause_reg + 8'd1;

    // Classify the word and work out the next state and the command.
    always_comb
    begin
        synced_next  = synced_reg;
        pos_next     = pos_reg;
        last_next    = last_reg;
        pause_next   = pause_reg;
        timeout_next = timeout_reg;
        slot_next    = slot_reg;
        cmd          = '0;

        case (opcode_t'(in_data.opcode))
            OP_TICK:
            begin
                if (timeout_reg != 8'd0)
                    timeout_next = timeout_reg - 8'd1;
                pause_next = pause_inc;
                if (pause_inc >= pause_limit_reg)
                    synced_next = 1'b0;
            end
            OP_EDGE:
            begin
                pause_next = 8'd0;
                if (in_data.pin_high)
                begin
                    timeout_next = timeout_reload_reg;
                    // A rising edge at position zero while synced starts a new ring slot.
                    if (synced_reg && pos_reg == 7'd0)
                    begin
                        if (slot_reg == SLOT_W'(HISTORY_DEPTH - 1))
                            slot_next = '0;
                        else
                            slot_next = slot_reg + 1'b1;
                    end
                    if (synced_reg && pos_reg < 7'(eff_limit))
                    begin
                        cmd.stored  = 1'b1;
                        cmd.channel = CH_IDX_W'(pos_reg);
                        cmd.width   = 16'(diff);
                        cmd.slot    = SLOT_IDX_W'(slot_next);
                    end
                    last_next = in_data.timestamp[CAP_W-1:0];
                    if (!synced_reg)
                    begin
                        synced_next = 1'b1;
                        pos_next    = 7'd0;
                    end
                    else if (pos_reg < POS_MAX)
                    begin
                        pos_next = pos_reg + 7'd1;
                    end
                end
            end
            OP_READ:
            begin
                if ({1'b0, in_data.read_channel} < 5'(MAX_CHANNELS)
                    && (in_data.read_latest
                        || {3'b0, in_data.read_slot} < 7'(HISTORY_DEPTH)))
                    cmd.rd_use = 1'b1;
                cmd.rd_latest  = in_data.read_latest;
                cmd.rd_channel = in_data.read_channel;
                cmd.rd_slot    = SLOT_IDX_W'(in_data.read_slot);
            end
            default:
            begin
            end
        endcase

        cmd.signal_present = (timeout_next != 8'd0);
        cmd.synced         = synced_next;
    end

    // State update on each accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            synced_reg  <= 1'b0;
            pos_reg     <= 7'd0;
            last_reg    <= '0;
            pause_reg   <= 8'd0;
            timeout_reg <= 8'd0;
            slot_reg    <= '0;
        end
        else if (accept)
        begin
            synced_reg  <= synced_next;
            pos_reg     <= pos_next;
            last_reg    <= last_next;
            pause_reg   <= pause_next;
            timeout_reg <= timeout_next;
            slot_reg    <= slot_next;
        end
    end

    // A width is only ever stored while the position is in a frame.
    a_store_synced: assert property (@(posedge clk) disable iff (!rst_n)
        push && push_cmd.stored |-> synced_reg && push_cmd.synced)
        else $error("width stored while unsynchronized");

endmodule

>>> hw/rtl/ppmd_queue.sv
module ppmd_queue
    import ppmd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic empty,
    output cmd_t head
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop) && count_reg != 2'd3)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue underflow");

endmodule

>>> hw/rtl/ppmd_back.sv
module ppmd_back
    import ppmd_pkg::*;
#(
    parameter int MAX_CHANNELS  = 10,
    parameter int HISTORY_DEPTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_empty,
    input  cmd_t      head,
    output logic      pop,
    output logic      clearing,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data
);

    localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int DEPTH  = MAX_CHANNELS * HISTORY_DEPTH;
    localparam int ADDR_W = $clog2(DEPTH);

    // History store and latest widths.
    logic [15:0] hist_mem [DEPTH];
    logic [15:0] latest_reg [MAX_CHANNELS];

    logic              clear_reg;
    logic [ADDR_W-1:0] clr_idx_reg;

    logic              out_valid_reg;
    logic              stored_reg;
    logic [3:0]        channel_reg;
    logic [15:0]       width_reg;
    logic [3:0]        slot_reg;
    logic              sp_reg;
    logic              synced_reg;
    logic              rd_use_reg;
    logic              rd_latest_reg;
    logic [15:0]       latest_q_reg;
    logic [15:0]       hist_q_reg;

    logic              advance;
    logic [CH_W-1:0]   ch_sel;
    logic [SLOT_IDX_W-1:0] slot_sel;
    logic [ADDR_W-1:0] mem_addr;
    logic              mem_we;
    logic              mem_re;
    logic [15:0]       mem_wdata;

    assign clearing = clear_reg;
    assign advance  = !clear_reg && !q_empty && (!out_valid_reg || out_ready);
    assign pop      = advance;

    // One store port: the write address of a stored width, else the read address.
    assign ch_sel   = head.stored ? CH_W'(head.channel) : CH_W'(head.rd_channel);
    assign slot_sel = head.stored ? head.slot : head.rd_slot;

    always_comb
    begin
        if (clear_reg)
        begin
            mem_addr  = clr_idx_reg;
            mem_we    = 1'b1;
            mem_wdata = 16'd0;
        end
        else
        begin
            mem_addr  = ADDR_W'(int'(ch_sel) * HISTORY_DEPTH + int'(slot_sel));
            mem_we    = advance && head.stored;
            mem_wdata = head.width;
        end
    end

    assign mem_re = advance && head.rd_use && !head.rd_latest;

    // History memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            hist_mem[mem_addr] <= mem_wdata;
        if (mem_re)
            hist_q_reg <= hist_mem[mem_addr];
    end

    // Clearing pass over the history memory after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg   <= 1'b1;
            clr_idx_reg <= '0;
        end
        else if (clear_reg)
        begin
            if (clr_idx_reg == ADDR_W'(DEPTH - 1))
                clear_reg <= 1'b0;
            else
                clr_idx_reg <= clr_idx_reg + 1'b1;
        end
    end

    // Latest width per channel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CHANNELS; i++)
                latest_reg[i] <= 16'd0;
        end
        else if (advance && head.stored)
        begin
            latest_reg[ch_sel] <= head.width;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && head.rd_use && head.rd_latest)
            latest_q_reg <= latest_reg[ch_sel];
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stored_reg    <= head.stored;
            channel_reg   <= head.channel;
            width_reg     <= head.width;
            slot_reg      <= head.slot[3:0];
            sp_reg        <= head.signal_present;
            synced_reg    <= head.synced;
            rd_use_reg    <= head.rd_use;
            rd_latest_reg <= head.rd_latest;
        end
    end

    assign out_valid               = out_valid_reg;
    assign out_data.stored         = stored_reg;
    assign out_data.channel        = channel_reg;
    assign out_data.width          = width_reg;
    assign out_data.slot           = slot_reg;
    assign out_data.signal_present = sp_reg;
    assign out_data.synced         = synced_reg;
    assign out_data.read_data      = !rd_use_reg ? 16'd0
                                   : (rd_latest_reg ? latest_q_reg : hist_q_reg);

    // No word may reach the store while the clearing pass owns the port.
    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        clear_reg |-> !advance && !out_valid_reg)
        else $error("word processed during clearing pass");

endmodule

>>> hw/rtl/ppm_channel_decoder.sv
// Decoder for RC pulse-position frames. It takes one word per clock while in_ready is
// high: a timer tick, a pin edge with its 16-bit timestamp, or a read of a stored width,
// and gives one output word for each, in order, via the queue and the output register.
// A two-entry queue parts the front end, which keeps the frame state, from the store
// side, which owns the latest-width registers and the single-port history memory; each
// word uses that port at most once, so the sustained rate is one word per cycle with
// out_ready high. After reset a clearing pass zeroes all MAX_CHANNELS * HISTORY_DEPTH
// history entries (160 by default), one a cycle, and in_ready stays low until it ends.
// Configuration writes are taken at any time and should be made while the block is idle.
module ppm_channel_decoder
    import ppmd_pkg::*;
#(
    parameter int MAX_CHANNELS  = 10,
    parameter int HISTORY_DEPTH = 16,
    parameter int TIME_WIDTH    = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_word_t   in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_word_t  out_data
);

    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    logic clearing;
    cmd_t push_cmd;
    cmd_t head;

    // Front end: classification and frame state.
    ppmd_front #(
        .MAX_CHANNELS  (MAX_CHANNELS),
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .TIME_WIDTH    (TIME_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .q_full    (q_full),
        .clearing  (clearing),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    // Queue between the two sides.
    ppmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .head     (head)
    );

    // Store side and output register.
    ppmd_back #(
        .MAX_CHANNELS  (MAX_CHANNELS),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .head      (head),
        .pop       (pop),
        .clearing  (clearing),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

>>> tb/ppmd_board_pkg.sv
package ppmd_board_pkg;

    import ppmd_pkg::*;

    localparam int N_CH   = 10;
    localparam int N_SLOT = 16;

    // Tracks the frame state of the decoder and the output words it owes.
    class ppm_decode_board;

        bit [7:0]  pause_lim;
        bit [7:0]  timeout_rel;
        bit [3:0]  chan_count;
        int        position;
        bit [15:0] last_ts;
        int        pause_cnt;
        int        timeout_cnt;
        int        ring_slot;
        bit [15:0] latest_w [N_CH];
        bit [15:0] history_w [N_CH][N_SLOT];
        out_word_t due_words [$];
        int        mismatches;

        function new();
            pause_lim   = PAUSE_LIMIT_RST;
            timeout_rel = TIMEOUT_RELOAD_RST;
            chan_count  = ACTIVE_CHANNELS_RST;
            position    = -1;
            last_ts     = '0;
            pause_cnt   = 0;
            timeout_cnt = 0;
            ring_slot   = 0;
            mismatches  = 0;
            for (int c = 0; c < N_CH; c++)
            begin
                latest_w[c] = '0;
                for (int s = 0; s < N_SLOT; s++)
                    history_w[c][s] = '0;
            end
        endfunction

        // Mirrors a register write made while the block is idle.
        function void set_reg(logic [1:0] index, logic [7:0] value);
            case (index)
                REG_PAUSE_LIMIT:     pause_lim   = value;
                REG_TIMEOUT_RELOAD:  timeout_rel = value;
                REG_ACTIVE_CHANNELS: chan_count  = value[3:0];
                default: ;
            endcase
        endfunction

        // Applies one input word to the frame state and returns the word it yields.
        function out_word_t decode_item(in_word_t w);
            out_word_t r;
            int        lim;
            bit [15:0] span;
            r = '0;
            case (w.opcode)
                OP_TICK:
                begin
                    if (timeout_cnt > 0)
                        timeout_cnt--;
                    if (pause_cnt < int'(PAUSE_MAX))
                        pause_cnt++;
                    if (pause_cnt >= int'(pause_lim))
                        position = -1;
                end
                OP_EDGE:
                begin
                    pause_cnt = 0;
                    if (w.pin_high)
                    begin
                        timeout_cnt = timeout_rel;
                        if (position == 0)
                            ring_slot = (ring_slot + 1) % N_SLOT;
                        lim = (int'(chan_count) > N_CH) ? N_CH : int'(chan_count);
                        if (position >= 0 && position < lim)
                        begin
                            span = w.timestamp - last_ts;
                            latest_w[position] = span;
                            history_w[position][ring_slot] = span;
                            r.stored  = 1'b1;
                            r.channel = 4'(position);
                            r.width   = span;
                            r.slot    = 4'(ring_slot);
                        end
                        last_ts = w.timestamp;
                        if (position < int'(POS_MAX))
                            position++;
                    end
                end
                OP_READ:
                begin
                    if (int'(w.read_channel) < N_CH)
                    begin
                        if (w.read_latest)
                            r.read_data = latest_w[w.read_channel];
                        else
                            r.read_data = history_w[w.read_channel][w.read_slot];
                    end
                end
                default: ;
            endcase
            r.signal_present = (timeout_cnt != 0);
            r.synced         = (position != -1);
            return r;
        endfunction

        function void accept_item(in_word_t w);
            due_words.push_back(decode_item(w));
        endfunction

        function int due_count();
            return due_words.size();
        endfunction

        function string show(out_word_t v);
            return $sformatf("stored=%0d ch=%0d width=%h slot=%0d rd=%h sp=%0d sy=%0d",
                             v.stored, v.channel, v.width, v.slot, v.read_data,
                             v.signal_present, v.synced);
        endfunction

        // Compares an accepted output word with the oldest one owed.
        function void check_output(out_word_t got);
            out_word_t want;
            string     bad;
            bad = "";
            if (due_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("output word with none due: %s", show(got));
                return;
            end
            want = due_words.pop_front();
            if (got.stored !== want.stored)
                bad = {bad, " stored"};
            if (got.channel !== want.channel)
                bad = {bad, " channel"};
            if (got.width !== want.width)
                bad = {bad, " width"};
            if (got.slot !== want.slot)
                bad = {bad, " slot"};
            if (got.read_data !== want.read_data)
                bad = {bad, " read_data"};
            if (got.signal_present !== want.signal_present)
                bad = {bad, " signal_present"};
            if (got.synced !== want.synced)
                bad = {bad, " synced"};
            if (bad != "")
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch in%s: expected %s, got %s", bad, show(want), show(got));
            end
        endfunction

    endclass

endpackage

>>> tb/tb_ppm_channel_decoder.sv
module tb_ppm_channel_decoder;

    import ppmd_pkg::*;
    import ppmd_board_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      cfg_write;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;
    logic      in_valid;
    logic      in_ready;
    in_word_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_word_t out_data;

    ppm_decode_board board;

    bit        hold_req;
    int        burst_left;
    int        cycles;
    int        sent_items;
    bit [15:0] ts_now;
    bit [7:0]  cur_pl;
    bit [3:0]  cur_ac;

    ppm_channel_decoder uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Free-running clock, period 4.
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 400000)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Output words are checked at the falling edge before the edge that takes them.
    always @(negedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_output(out_data);
    end

    // Receiver: changing stall patterns, plus a long hold-off when asked.
    initial
    begin
        int mode;
        int left;
        int per;
        int step;
        mode = 0;
        left = 0;
        per = 2;
        step = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom % 3;
                    left = $urandom_range(250, 50);
                    per = $urandom_range(6, 2);
                end
                left--;
                step++;
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= (($urandom % 100) < 60);
                    default: out_ready <= ((step % per) != 0);
                endcase
            end
        end
    end

    function automatic in_word_t make_word(opcode_t op, bit pin, bit [15:0] ts,
                                           bit [3:0] ch, bit [3:0] sl, bit lat);
        in_word_t w;
        w.opcode       = op;
        w.pin_high     = pin;
        w.timestamp    = ts;
        w.read_channel = ch;
        w.read_slot    = sl;
        w.read_latest  = lat;
        return w;
    endfunction

    // Offers one word in bursts with random gaps and waits until it is taken.
    task automatic send_word(in_word_t w);
        int  gap;
        bit  fire;
        if (burst_left == 0)
        begin
            gap = (($urandom % 5) == 0) ? $urandom_range(25, 0) : $urandom_range(4, 0);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = (($urandom % 6) == 0) ? $urandom_range(150, 60)
                                                : $urandom_range(16, 1);
        end
        burst_left--;
        in_data  <= w;
        in_valid <= 1'b1;
        fire = 1'b0;
        while (!fire)
        begin
            @(negedge clk);
            fire = in_ready;
            @(posedge clk);
        end
        board.accept_item(w);
        sent_items++;
    endtask

    task automatic send_tick();
        send_word(make_word(OP_TICK, $urandom, $urandom, $urandom, $urandom, $urandom));
    endtask

    task automatic send_edge(bit rise, bit [15:0] ts);
        send_word(make_word(OP_EDGE, rise, ts, $urandom, $urandom, $urandom));
    endtask

    task automatic send_read(bit [3:0] ch, bit [3:0] sl, bit lat);
        send_word(make_word(OP_READ, $urandom, $urandom, ch, sl, lat));
    endtask

    // Writes all three registers on consecutive edges; the block is idle.
    task automatic program_regs(bit [7:0] pl, bit [7:0] tr, bit [3:0] ac);
        cfg_write <= 1'b1;
        cfg_index <= REG_PAUSE_LIMIT;
        cfg_data  <= pl;
        @(posedge clk);
        cfg_index <= REG_TIMEOUT_RELOAD;
        cfg_data  <= tr;
        @(posedge clk);
        cfg_index <= REG_ACTIVE_CHANNELS;
        cfg_data  <= {4'b0000, ac};
        @(posedge clk);
        cfg_write <= 1'b0;
        board.set_reg(REG_PAUSE_LIMIT, pl);
        board.set_reg(REG_TIMEOUT_RELOAD, tr);
        board.set_reg(REG_ACTIVE_CHANNELS, {4'b0000, ac});
        cur_pl = pl;
        cur_ac = ac;
    endtask

    // Lets every owed word drain before the next phase.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (board.due_count() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // One frame: a sync pause, a sync edge, then a train of channel pulses.
    task automatic send_frame();
        int        ticks;
        int        n;
        bit [15:0] w;
        if (cur_pl <= 20)
            ticks = $urandom_range(int'(cur_pl) + 1, (cur_pl > 0) ? int'(cur_pl) - 1 : 0);
        else
            ticks = $urandom_range(2, 0);
        repeat (ticks) send_tick();
        ts_now += $urandom_range(6000, 3000);
        send_edge(1'b1, ts_now);
        n = int'(cur_ac) + $urandom_range(2, 0);
        for (int k = 0; k < n; k++)
        begin
            if (($urandom % 4) != 0)
                send_edge(1'b0, ts_now + $urandom_range(400, 200));
            w = (($urandom % 10) == 0) ? 16'($urandom) : 16'($urandom_range(2100, 900));
            ts_now += w;
            send_edge(1'b1, ts_now);
            if (($urandom % 6) == 0)
                send_read($urandom_range(9, 0), $urandom, $urandom);
            if (($urandom % 8) == 0)
                send_tick();
        end
        if (($urandom % 2) == 0)
            send_read($urandom, $urandom, $urandom);
    endtask

    // Mostly well-formed frames, with noise words and broken sequences mixed in.
    // Runs until about count words have been taken.
    task automatic run_random(int count);
        int start;
        int pick;
        start = sent_items;
        while (sent_items - start < count)
        begin
            pick = $urandom % 100;
            if (pick < 75)
            begin
                send_frame();
            end
            else if (pick < 88)
            begin
                repeat (4)
                begin
                    send_word(in_word_t'($urandom));
                end
            end
            else
            begin
                // Edges with no pause in between, then a pause that falls short.
                repeat ($urandom_range(4, 1))
                begin
                    ts_now += $urandom;
                    send_edge($urandom, ts_now);
                end
                repeat ((cur_pl > 1) ? $urandom_range(int'(cur_pl) - 1, 0) : 0)
                    send_tick();
            end
        end
    endtask

    // Directed words at the reset settings.
    task automatic run_directed();
        send_read(4'd0, 4'd0, 1'b1);
        send_read(4'd15, 4'd15, 1'b0);
        send_read(4'd9, 4'd15, 1'b1);
        send_word(make_word(OP_NONE, 1'b1, 16'hFFFF, 4'hF, 4'hF, 1'b1));
        send_edge(1'b0, 16'hFFFF);
        // First rising edge only starts the frame.
        send_edge(1'b1, 16'hFFF0);
        // Interval across the timer wrap, then a zero and a full-scale interval.
        send_edge(1'b1, 16'h0010);
        send_edge(1'b1, 16'h0010);
        send_edge(1'b1, 16'h000F);
        send_edge(1'b0, 16'h0000);
        send_read(4'd2, 4'd0, 1'b1);
        send_read(4'd0, 4'd1, 1'b0);
        send_read(4'd1, 4'd1, 1'b0);
        // Pause long enough to lose sync.
        repeat (4) send_tick();
        send_read(4'd10, 4'd1, 1'b1);
        send_read(4'd12, 4'd3, 1'b0);
        send_word(make_word(OP_NONE, 1'b0, 16'h0000, 4'h0, 4'h0, 1'b0));
        send_edge(1'b1, 16'h8000);
        send_edge(1'b1, 16'h8001);
        repeat (3) send_tick();
        ts_now = 16'h8001;
    endtask

    // Main sequence of phases.
    initial
    begin
        board = new();
        hold_req = 1'b0;
        burst_left = 0;
        cycles = 0;
        sent_items = 0;
        ts_now = '0;
        cur_pl = PAUSE_LIMIT_RST;
        cur_ac = ACTIVE_CHANNELS_RST;
        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= REG_PAUSE_LIMIT;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random(110);

        wait_idle();
        program_regs(8'd1, 8'd0, 4'd1);
        hold_req = 1'b1;
        run_random(110);

        // Saturate the pause counter, then run the position up to its limit.
        wait_idle();
        program_regs(8'd255, 8'd255, 4'd10);
        repeat (260) send_tick();
        repeat (135)
        begin
            ts_now += $urandom_range(2100, 900);
            send_edge(1'b1, ts_now);
        end
        run_random(40);

        // Pause limit zero and a channel count above the maximum.
        wait_idle();
        program_regs(8'd0, 8'd1, 4'd15);
        run_random(110);

        // No channel is measured.
        wait_idle();
        program_regs(8'd2, 8'd200, 4'd0);
        run_random(90);

        wait_idle();
        program_regs($urandom_range(8, 1), $urandom, $urandom_range(10, 1));
        run_random(110);

        wait_idle();
        program_regs(8'd5, 8'd12, 4'd4);
        hold_req = 1'b1;
        run_random(110);

        wait_idle();
        repeat (20) @(posedge clk);
        if (board.mismatches == 0 && board.due_count() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
